// File: hw/rtl/crc8cfd_pkg.sv
// Shared types, constants and the CRC-8 byte update for the command frame decoder.
// Used by the front end, event queue, back end and top level; no dependencies.
package crc8cfd_pkg;

  // Frame limits and protocol bytes
  localparam int unsigned MAX_FRAME   = 256;
  localparam logic [8:0]  LEN_MAX     = 9'(MAX_FRAME - 4);
  localparam logic [7:0]  CH_PREAMBLE = 8'h41;
  localparam logic [7:0]  TYPE_FREQ   = 8'h44;
  localparam logic [7:0]  TYPE_PORT   = 8'h45;
  localparam logic [7:0]  CRC_POLY    = 8'h31;
  localparam logic [7:0]  REPLY_BIT   = 8'h80;
  localparam logic [31:0] FREQ_RESET  = 32'd1000;

  // Depth of the queue between front and back end
  localparam int unsigned EVT_DEPTH   = 2;

  // Status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_CRC_ERR = 2'd1;
  localparam logic [1:0] ST_BAD_LEN = 2'd2;

  // Command codes
  localparam logic [1:0] DONE_NONE = 2'd0;
  localparam logic [1:0] DONE_FREQ = 2'd1;
  localparam logic [1:0] DONE_PORT = 2'd2;

  // Parser phases
  typedef enum logic [2:0] {
    PH_HUNT,
    PH_CNT,
    PH_TYPE,
    PH_LEN,
    PH_PAYLOAD,
    PH_CRC
  } phase_e;

  // Finished-frame event handed from front to back end
  typedef struct packed {
    logic        len_bad;
    logic        crc_ok;
    logic [7:0]  ftype;
    logic [7:0]  reply_crc;
    logic [31:0] value;
  } evt_t;

  // One byte of CRC-8, MSB first, polynomial 0x31
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// File: hw/rtl/crc8cfd_front.sv
// Front end: hunts for the preamble, parses header and payload, runs both CRCs
// and emits one event per finished or rejected frame. Depends on crc8cfd_pkg.
module crc8cfd_front
  import crc8cfd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       byte_acc_i,
  input  logic [7:0] rx_byte_i,
  input  logic       seed_we_i,
  input  logic [7:0] seed_i,
  output logic       evt_push_o,
  output evt_t       evt_o
);

  phase_e      phase_q, phase_d;
  logic [7:0]  seed_q;
  logic [7:0]  cnt_q, cnt_d;
  logic [7:0]  len_q, len_d;
  logic [7:0]  type_q, type_d;
  logic [7:0]  chk_q, chk_d;
  logic [7:0]  ans_q, ans_d;
  logic [31:0] shift_q, shift_d;

  logic [7:0]  chk_new, ans_new, ans_in, crc_base;
  logic [7:0]  cnt_inc;
  logic        len_bad, pay_last;

  // Shared CRC updates for the current word
  assign crc_base = (phase_q == PH_HUNT) ? seed_q : chk_q;
  assign ans_in   = (phase_q == PH_TYPE) ? (rx_byte_i | REPLY_BIT) : rx_byte_i;
  assign chk_new  = crc8_byte(crc_base, rx_byte_i);
  assign ans_new  = crc8_byte(ans_q, ans_in);
  assign len_bad  = (rx_byte_i == 8'd0) || ({1'b0, rx_byte_i} > LEN_MAX);
  assign cnt_inc  = cnt_q + 8'd1;
  assign pay_last = cnt_inc >= (len_q - 8'd1);

  // Next phase
  always_comb begin
    phase_d = phase_q;
    if (byte_acc_i) begin
      case (phase_q)
        PH_HUNT: begin
          if (rx_byte_i == CH_PREAMBLE) phase_d = PH_CNT;
        end
        PH_CNT:  phase_d = PH_TYPE;
        PH_TYPE: phase_d = PH_LEN;
        PH_LEN: begin
          if (len_bad) phase_d = PH_HUNT;
          else if (rx_byte_i == 8'd1) phase_d = PH_CRC;
          else phase_d = PH_PAYLOAD;
        end
        PH_PAYLOAD: begin
          if (pay_last) phase_d = PH_CRC;
        end
        PH_CRC:  phase_d = PH_HUNT;
        default: phase_d = PH_HUNT;
      endcase
    end
  end

  // Datapath updates and event output
  always_comb begin
    cnt_d   = cnt_q;
    len_d   = len_q;
    type_d  = type_q;
    chk_d   = chk_q;
    ans_d   = ans_q;
    shift_d = shift_q;
    evt_push_o      = 1'b0;
    evt_o.len_bad   = (phase_q == PH_LEN);
    evt_o.crc_ok    = (rx_byte_i == chk_q);
    evt_o.ftype     = type_q;
    evt_o.reply_crc = (phase_q == PH_LEN) ? 8'd0 : ans_q;
    evt_o.value     = shift_q;
    if (byte_acc_i) begin
      case (phase_q)
        PH_HUNT: begin
          if (rx_byte_i == CH_PREAMBLE) begin
            chk_d   = chk_new;
            ans_d   = chk_new;
            cnt_d   = 8'd0;
            len_d   = 8'd0;
            type_d  = 8'd0;
            shift_d = 32'd0;
          end
        end
        PH_CNT: begin
          chk_d = chk_new;
          ans_d = ans_new;
        end
        PH_TYPE: begin
          type_d = rx_byte_i;
          chk_d  = chk_new;
          ans_d  = ans_new;
        end
        PH_LEN: begin
          len_d = rx_byte_i;
          if (len_bad) begin
            evt_push_o = 1'b1;
          end else begin
            chk_d = chk_new;
            ans_d = ans_new;
            cnt_d = 8'd0;
          end
        end
        PH_PAYLOAD: begin
          chk_d   = chk_new;
          ans_d   = ans_new;
          shift_d = {shift_q[23:0], rx_byte_i};
          cnt_d   = cnt_inc;
        end
        PH_CRC: begin
          evt_push_o = 1'b1;
        end
        default: begin
          evt_push_o = 1'b0;
        end
      endcase
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT;
      seed_q  <= 8'd0;
      cnt_q   <= 8'd0;
      len_q   <= 8'd0;
      type_q  <= 8'd0;
      chk_q   <= 8'd0;
      ans_q   <= 8'd0;
      shift_q <= 32'd0;
    end else begin
      phase_q <= phase_d;
      if (seed_we_i) seed_q <= seed_i;
      cnt_q   <= cnt_d;
      len_q   <= len_d;
      type_q  <= type_d;
      chk_q   <= chk_d;
      ans_q   <= ans_d;
      shift_q <= shift_d;
    end
  end

endmodule

// File: hw/rtl/crc8cfd_queue.sv
// Short event queue between front and back end so each side stalls on its own.
// Depends on crc8cfd_pkg for the event type.
module crc8cfd_queue
  import crc8cfd_pkg::*;
#(
  parameter int unsigned DEPTH = EVT_DEPTH
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  evt_t push_data_i,
  input  logic pop_i,
  output logic valid_o,
  output logic full_o,
  output evt_t head_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  evt_t          mem_q [DEPTH];
  logic [PW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CW-1:0] count_q;
  logic          do_push, do_pop;

  assign valid_o = (count_q != '0);
  assign full_o  = (count_q == CW'(DEPTH));
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Store entries
  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= push_data_i;
  end

  // Advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
      end
      if (do_push && !do_pop) count_q <= count_q + CW'(1);
      else if (do_pop && !do_push) count_q <= count_q - CW'(1);
    end
  end

endmodule

// File: hw/rtl/crc8cfd_back.sv
// Back end: carries out frame events, owns the frequency and port registers
// and holds the result word in an output register. Depends on crc8cfd_pkg.
module crc8cfd_back
  import crc8cfd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        evt_valid_i,
  input  evt_t        evt_i,
  output logic        evt_pop_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [1:0]  command_done_o,
  output logic [7:0]  reply_type_o,
  output logic [7:0]  reply_crc_o,
  output logic [31:0] frequency_value_o,
  output logic [31:0] port_value_o
);

  logic        out_valid_q;
  logic [31:0] freq_q, freq_d;
  logic [31:0] port_q, port_d;
  logic [1:0]  status_q, status_d;
  logic [1:0]  done_q, done_d;
  logic [7:0]  rtype_q;
  logic [7:0]  rcrc_q;

  // Take the next event when the output register is free or being emptied
  assign evt_pop_o = evt_valid_i && (!out_valid_q || out_ready_i);

  // Decide status and command
  always_comb begin
    freq_d   = freq_q;
    port_d   = port_q;
    done_d   = DONE_NONE;
    status_d = ST_CRC_ERR;
    if (evt_i.len_bad) begin
      status_d = ST_BAD_LEN;
    end else if (evt_i.crc_ok) begin
      status_d = ST_OK;
      if (evt_i.ftype == TYPE_FREQ) begin
        freq_d = evt_i.value;
        done_d = DONE_FREQ;
      end else if (evt_i.ftype == TYPE_PORT) begin
        port_d = evt_i.value;
        done_d = DONE_PORT;
      end
    end
  end

  // Command registers and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      freq_q      <= FREQ_RESET;
      port_q      <= 32'd0;
    end else begin
      if (evt_pop_o) begin
        out_valid_q <= 1'b1;
        freq_q      <= freq_d;
        port_q      <= port_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (evt_pop_o) begin
      status_q <= status_d;
      done_q   <= done_d;
      rtype_q  <= evt_i.ftype | REPLY_BIT;
      rcrc_q   <= evt_i.reply_crc;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign status_o          = status_q;
  assign command_done_o    = done_q;
  assign reply_type_o      = rtype_q;
  assign reply_crc_o       = rcrc_q;
  assign frequency_value_o = freq_q;
  assign port_value_o      = port_q;

endmodule

// File: hw/rtl/crc8_command_frame_decoder.sv
// Top level of the CRC-8 command frame decoder: front end, event queue, back end.
// Depends on crc8cfd_pkg, crc8cfd_front, crc8cfd_queue and crc8cfd_back.
//
//   Channel   Direction  Width  Contents
//   s_axis    in         8      rx_byte
//   m_axis    out        88     status, command_done, reply_type, reply_crc,
//                               frequency_value, port_value
//   cfg       in         8      crc_seed (write only)
//
// One byte is accepted per cycle while the event queue is not full; the front end
// runs both CRC-8 updates in the cycle the byte arrives. A frame's last byte puts
// an event in the two-entry event queue; the back end registers its result word.
// Reset puts the parser in preamble hunt, the seed and CRCs to zero, the
// frequency register to 1000 and the port register to zero.
// s_axis_tready drops only while the event queue is full, which happens when
// m_axis is stalled and two more frames have finished.
module crc8_command_frame_decoder
  import crc8cfd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [1:0] status, [3:2] command_done, [11:4] reply_type, [19:12] reply_crc,
  // [51:20] frequency_value, [83:52] port_value, [87:84] zero
  output logic [87:0] m_axis_tdata,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i
);

  logic        byte_acc;
  logic        evt_push, q_full, q_valid, q_pop;
  evt_t        evt_front, evt_head;
  logic [1:0]  status, command_done;
  logic [7:0]  reply_type, reply_crc;
  logic [31:0] frequency_value, port_value;

  assign s_axis_tready = !q_full;
  assign byte_acc      = s_axis_tvalid && s_axis_tready;

  crc8cfd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .byte_acc_i (byte_acc),
    .rx_byte_i  (s_axis_tdata),
    .seed_we_i  (cfg_we_i),
    .seed_i     (cfg_wdata_i),
    .evt_push_o (evt_push),
    .evt_o      (evt_front)
  );

  crc8cfd_queue #(
    .DEPTH (EVT_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (evt_push),
    .push_data_i (evt_front),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .full_o      (q_full),
    .head_o      (evt_head)
  );

  crc8cfd_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .evt_valid_i       (q_valid),
    .evt_i             (evt_head),
    .evt_pop_o         (q_pop),
    .out_valid_o       (m_axis_tvalid),
    .out_ready_i       (m_axis_tready),
    .status_o          (status),
    .command_done_o    (command_done),
    .reply_type_o      (reply_type),
    .reply_crc_o       (reply_crc),
    .frequency_value_o (frequency_value),
    .port_value_o      (port_value)
  );

  // Pack the result word
  assign m_axis_tdata = {4'd0, port_value, frequency_value, reply_crc, reply_type,
                         command_done, status};

`ifndef SYNTHESIS
  // An event is never pushed into a full queue
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(evt_push && q_full))
    else $error("event pushed into full queue");

  // A rejected length carries no command and a zero reply CRC
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && status == ST_BAD_LEN) |-> (command_done == DONE_NONE && reply_crc == 8'd0))
    else $error("bad length result carries command or CRC");

  // A command is reported only for a good frame
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && command_done != DONE_NONE) |-> (status == ST_OK))
    else $error("command reported for a failed frame");
`endif

endmodule

// File: bench/tb_crc8_command_frame_decoder.sv
// Self-checking bench for crc8_command_frame_decoder: byte stream in, reply words out.
// Depends on crc8cfd_pkg and the decoder RTL; predicts each reply with its own frame tracker.
module tb_crc8_command_frame_decoder;
  import crc8cfd_pkg::*;

  localparam int CLK_HALF       = 4;
  localparam int SETTLE_CYCLES  = 12;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int PHASE_BYTES    = 150;

  // Reply word as laid out on m_axis_tdata, lowest field last
  typedef struct packed {
    logic [3:0]  pad;
    logic [31:0] port;
    logic [31:0] freq;
    logic [7:0]  rcrc;
    logic [7:0]  rtype;
    logic [1:0]  done;
    logic [1:0]  status;
  } reply_t;

  // How a table byte is formed: as written, or the running frame CRC (good or corrupted)
  typedef enum logic [1:0] {
    BK_DATA,
    BK_CRC_GOOD,
    BK_CRC_BAD
  } byte_kind_e;

  typedef struct {
    logic [7:0] data;
    byte_kind_e kind;
    bit         has_lit;
    reply_t     lit;
  } stim_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [87:0] m_axis_tdata;
  logic        cfg_we_i = 1'b0;
  logic [7:0]  cfg_wdata_i = 8'h00;

  // Frame tracker state
  phase_e      ph = PH_HUNT;
  logic [8:0]  nbytes = '0;
  logic [7:0]  flen = '0;
  logic [7:0]  ftype = '0;
  logic [7:0]  chk_crc = '0;
  logic [7:0]  ans_crc = '0;
  logic [31:0] shift = '0;
  logic [31:0] freq_reg = FREQ_RESET;
  logic [31:0] port_reg = '0;
  logic [7:0]  seed = '0;

  reply_t      reply_q[$];
  stim_row_t   dir_rows[$];
  reply_t      seen;
  reply_t      want;

  int src_idle_pct = 0;
  int sink_stall_pct = 0;
  int n_errors = 0;
  int n_bytes = 0;
  int n_replies = 0;
  int n_ok = 0;
  int n_crc_err = 0;
  int n_bad_len = 0;
  int n_seeds = 1;
  int quiet_cycles = 0;

  crc8_command_frame_decoder u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always #CLK_HALF clk_i = ~clk_i;

  // Shift one byte into a CRC-8 register bit by bit, MSB first
  function automatic logic [7:0] crc8_shift_in(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    logic       fb;
    c = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = c[7] ^ b[i];
      c  = {c[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
    end
    return c;
  endfunction

  function automatic reply_t pack_reply(input logic [1:0] st, input logic [1:0] dn,
                                        input logic [7:0] rt, input logic [7:0] rc,
                                        input logic [31:0] fq, input logic [31:0] pt);
    reply_t r;
    r        = '0;
    r.status = st;
    r.done   = dn;
    r.rtype  = rt;
    r.rcrc   = rc;
    r.freq   = fq;
    r.port   = pt;
    return r;
  endfunction

  // Advance the frame tracker by one received byte; flag a reply when a frame ends
  task automatic track_byte(input logic [7:0] b, output bit has_reply, output reply_t r);
    logic [1:0] st;
    logic [1:0] dn;
    has_reply = 1'b0;
    r         = '0;
    case (ph)
      PH_HUNT: begin
        if (b == CH_PREAMBLE) begin
          chk_crc = crc8_shift_in(seed, b);
          ans_crc = chk_crc;
          nbytes  = '0;
          flen    = '0;
          ftype   = '0;
          shift   = '0;
          ph      = PH_CNT;
        end
      end
      PH_CNT: begin
        chk_crc = crc8_shift_in(chk_crc, b);
        ans_crc = crc8_shift_in(ans_crc, b);
        ph      = PH_TYPE;
      end
      PH_TYPE: begin
        ftype   = b;
        chk_crc = crc8_shift_in(chk_crc, b);
        ans_crc = crc8_shift_in(ans_crc, b | REPLY_BIT);
        ph      = PH_LEN;
      end
      PH_LEN: begin
        flen = b;
        if (b == 8'h00 || int'(b) + 4 > int'(MAX_FRAME)) begin
          ph        = PH_HUNT;
          has_reply = 1'b1;
          r = pack_reply(ST_BAD_LEN, DONE_NONE, ftype | REPLY_BIT, 8'h00, freq_reg, port_reg);
        end else begin
          chk_crc = crc8_shift_in(chk_crc, b);
          ans_crc = crc8_shift_in(ans_crc, b);
          nbytes  = '0;
          ph      = (b == 8'h01) ? PH_CRC : PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        chk_crc = crc8_shift_in(chk_crc, b);
        ans_crc = crc8_shift_in(ans_crc, b);
        shift   = {shift[23:0], b};
        nbytes  = nbytes + 9'd1;
        if (nbytes >= {1'b0, flen} - 9'd1) begin
          ph = PH_CRC;
        end
      end
      default: begin
        // CRC byte: load a register only on a match
        ph = PH_HUNT;
        st = ST_CRC_ERR;
        dn = DONE_NONE;
        if (b == chk_crc) begin
          st = ST_OK;
          if (ftype == TYPE_FREQ) begin
            freq_reg = shift;
            dn       = DONE_FREQ;
          end else if (ftype == TYPE_PORT) begin
            port_reg = shift;
            dn       = DONE_PORT;
          end
        end
        has_reply = 1'b1;
        r = pack_reply(st, dn, ftype | REPLY_BIT, ans_crc, freq_reg, port_reg);
      end
    endcase
  endtask

  // Send one byte, wait for its handshake, then log the reply it causes
  task automatic deliver(input logic [7:0] b, input bit use_lit, input reply_t lit);
    bit     has_reply;
    reply_t r;
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk_i); while (!s_axis_tready);
    n_bytes++;
    track_byte(b, has_reply, r);
    if (has_reply) begin
      reply_q.push_back(use_lit ? lit : r);
    end
  endtask

  task automatic add_row(input logic [7:0] d, input byte_kind_e k,
                         input bit has_lit, input reply_t lit);
    stim_row_t row;
    row.data    = d;
    row.kind    = k;
    row.has_lit = has_lit;
    row.lit     = lit;
    dir_rows.push_back(row);
  endtask

  // One random frame: mostly well formed, sometimes preceded by noise or cut short.
  // A nonzero fixed_len forces a frame of that length with no noise and no cut.
  task automatic send_frame(input int fixed_len);
    int         len;
    int         total;
    int         cut;
    int         pick;
    bit         crc_bad;
    logic [7:0] kind_b;
    logic [7:0] b;
    if (fixed_len == 0 && $urandom_range(9) == 0) begin
      repeat ($urandom_range(1, 3)) deliver(8'($urandom_range(255)), 1'b0, '0);
    end
    case ($urandom_range(3))
      0:       kind_b = TYPE_FREQ;
      1:       kind_b = TYPE_PORT;
      default: kind_b = 8'($urandom_range(255));
    endcase
    pick = $urandom_range(99);
    if (fixed_len != 0)  len = fixed_len;
    else if (pick < 4)   len = 0;
    else if (pick < 8)   len = $urandom_range(253, 255);
    else if (pick < 18)  len = $urandom_range(9, 40);
    else                 len = $urandom_range(1, 8);
    total   = (len == 0 || len > 252) ? 4 : len + 4;
    cut     = (fixed_len == 0 && $urandom_range(9) == 0) ? $urandom_range(1, total - 1) : total;
    crc_bad = ($urandom_range(99) < 15);
    for (int k = 0; k < cut; k++) begin
      if (k == 0)               b = CH_PREAMBLE;
      else if (k == 2)          b = kind_b;
      else if (k == 3)          b = len[7:0];
      else if (k == total - 1)  b = crc_bad ? chk_crc ^ 8'($urandom_range(1, 255)) : chk_crc;
      else                      b = 8'($urandom_range(255));
      deliver(b, 1'b0, '0);
    end
  endtask

  // Drop valid, wait for every reply, then give the back end time to go quiet
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (reply_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_seed(input logic [7:0] v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    seed = v;
    n_seeds++;
  endtask

  task automatic check_field(input string name, input logic [31:0] want_v,
                             input logic [31:0] got_v);
    if (want_v !== got_v) begin
      $error("%s: expected %0h, got %0h", name, want_v, got_v);
      n_errors++;
    end
  endtask

  // Random backpressure on the reply side
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  // Compare each accepted reply word against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      seen = m_axis_tdata;
      if (reply_q.size() == 0) begin
        $error("reply word %h with nothing predicted", m_axis_tdata);
        n_errors++;
      end else begin
        want = reply_q.pop_front();
        check_field("status", 32'(want.status), 32'(seen.status));
        check_field("command_done", 32'(want.done), 32'(seen.done));
        check_field("reply_type", 32'(want.rtype), 32'(seen.rtype));
        check_field("reply_crc", 32'(want.rcrc), 32'(seen.rcrc));
        check_field("frequency_value", want.freq, seen.freq);
        check_field("port_value", want.port, seen.port);
        check_field("pad", 32'(want.pad), 32'(seen.pad));
        n_replies++;
        case (seen.status)
          ST_OK:      n_ok++;
          ST_CRC_ERR: n_crc_err++;
          default:    n_bad_len++;
        endcase
      end
    end
  end

  // Stop the run when nothing moves on either side for too long
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    logic [7:0] b;
    int         src_mix[4];
    int         sink_mix[4];
    logic [7:0] next_seed[3];
    src_mix   = '{0, 50, 0, 31};
    sink_mix  = '{0, 0, 50, 31};
    next_seed = '{8'h00, 8'($urandom_range(1, 254)), 8'h80};

    // Zero length right after reset: registers still at their reset values
    add_row(CH_PREAMBLE, BK_DATA, 1'b0, '0);
    add_row(8'hFF, BK_DATA, 1'b0, '0);
    add_row(8'h51, BK_DATA, 1'b0, '0);
    add_row(8'h00, BK_DATA, 1'b1,
            pack_reply(ST_BAD_LEN, DONE_NONE, 8'hD1, 8'h00, FREQ_RESET, 32'h0));
    // Oversize length, largest byte values
    add_row(CH_PREAMBLE, BK_DATA, 1'b0, '0);
    add_row(8'h00, BK_DATA, 1'b0, '0);
    add_row(8'h7F, BK_DATA, 1'b0, '0);
    add_row(8'hFF, BK_DATA, 1'b1,
            pack_reply(ST_BAD_LEN, DONE_NONE, 8'hFF, 8'h00, FREQ_RESET, 32'h0));
    // Empty payload on a frequency frame loads zero
    add_row(CH_PREAMBLE, BK_DATA, 1'b0, '0);
    add_row(8'h01, BK_DATA, 1'b0, '0);
    add_row(TYPE_FREQ, BK_DATA, 1'b0, '0);
    add_row(8'h01, BK_DATA, 1'b0, '0);
    add_row(8'h00, BK_CRC_GOOD, 1'b0, '0);
    // Port frame with five payload bytes: the first one shifts out
    add_row(CH_PREAMBLE, BK_DATA, 1'b0, '0);
    add_row(8'h02, BK_DATA, 1'b0, '0);
    add_row(TYPE_PORT, BK_DATA, 1'b0, '0);
    add_row(8'h06, BK_DATA, 1'b0, '0);
    add_row(8'hFF, BK_DATA, 1'b0, '0);
    add_row(8'h00, BK_DATA, 1'b0, '0);
    add_row(8'h12, BK_DATA, 1'b0, '0);
    add_row(8'h34, BK_DATA, 1'b0, '0);
    add_row(8'h56, BK_DATA, 1'b0, '0);
    add_row(8'h00, BK_CRC_GOOD, 1'b0, '0);
    // CRC mismatch: no register changes
    add_row(CH_PREAMBLE, BK_DATA, 1'b0, '0);
    add_row(8'h03, BK_DATA, 1'b0, '0);
    add_row(TYPE_FREQ, BK_DATA, 1'b0, '0);
    add_row(8'h01, BK_DATA, 1'b0, '0);
    add_row(8'h00, BK_CRC_BAD, 1'b0, '0);
    // Open a frame and leave it pending across the seed write
    add_row(CH_PREAMBLE, BK_DATA, 1'b0, '0);

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Walk the directed table
    foreach (dir_rows[i]) begin
      case (dir_rows[i].kind)
        BK_CRC_GOOD: b = chk_crc;
        BK_CRC_BAD:  b = chk_crc ^ 8'h5A;
        default:     b = dir_rows[i].data;
      endcase
      deliver(b, dir_rows[i].has_lit, dir_rows[i].lit);
    end
    settle();
    write_seed(8'hFF);

    // Random frames under each idle and stall mix
    for (int p = 0; p < 4; p++) begin
      src_idle_pct   = src_mix[p];
      sink_stall_pct = sink_mix[p];
      if (p == 3) begin
        send_frame(252);
      end
      while (n_bytes < 29 + (p + 1) * PHASE_BYTES + ((p == 3) ? 256 : 0)) begin
        send_frame(0);
      end
      settle();
      if (p < 3) begin
        write_seed(next_seed[p]);
      end
    end

    $display("Sent %0d bytes; checked %0d replies (%0d ok, %0d CRC errors, %0d length rejects)",
             n_bytes, n_replies, n_ok, n_crc_err, n_bad_len);
    $display("across four idle/stall mixes and %0d CRC seed settings", n_seeds);
    if (n_errors == 0 && reply_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: crc8_command_frame_decoder.f
hw/rtl/crc8cfd_pkg.sv
hw/rtl/crc8cfd_front.sv
hw/rtl/crc8cfd_queue.sv
hw/rtl/crc8cfd_back.sv
hw/rtl/crc8_command_frame_decoder.sv
bench/tb_crc8_command_frame_decoder.sv
